// ===== src/prim_spanning_tree_weight_assert.svh =====
// assertion macros shared by the spanning tree weight block
// no dependencies; files that check take it by include
`ifndef PRIM_SPANNING_TREE_WEIGHT_ASSERT_SVH
`define PRIM_SPANNING_TREE_WEIGHT_ASSERT_SVH

// same-cycle implication
`define PST_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pst assertion failed");

// next-cycle implication
`define PST_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pst assertion failed");

`endif

// ===== src/pst_pkg.sv =====
// shared types and constants for the spanning tree weight block
// no dependencies
package pst_pkg;

  localparam int VTX_BITS   = 10;
  localparam int CNT_BITS   = VTX_BITS + 1;
  localparam int COST_BITS  = 16;
  localparam int TOTAL_BITS = 26;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_RUN   = 2'd2;

  localparam logic [2:0] OP_IDLE     = 3'd0;
  localparam logic [2:0] OP_INIT     = 3'd1;
  localparam logic [2:0] OP_SCAN_RST = 3'd2;
  localparam logic [2:0] OP_SCAN     = 3'd3;
  localparam logic [2:0] OP_RELAX    = 3'd4;
  localparam logic [2:0] OP_ACCUM    = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic       cand_visited;
    logic       cand_reached;
  } pst_cmd_t;

  typedef struct packed {
    logic found;
    logic relax_hit;
  } pst_stat_t;

endpackage

// ===== src/pst_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module pst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/pst_unit.sv =====
// shared compare unit: least-distance selection, relax test, saturating total
// depends on pst_pkg
module pst_unit import pst_pkg::*; #(
  parameter int DIST_BITS = 16,
  parameter int IDX_BITS  = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pst_cmd_t              cmd,
  input  logic [IDX_BITS-1:0]   cand_idx,
  input  logic [DIST_BITS-1:0]  cand_dist,
  input  logic [DIST_BITS-1:0]  edge_w,
  output pst_stat_t             stat,
  output logic [IDX_BITS-1:0]   best_idx,
  output logic [DIST_BITS-1:0]  best_dist,
  output logic [TOTAL_BITS-1:0] total
);

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  logic                  found_r, found_nxt;
  logic [IDX_BITS-1:0]   best_idx_r, best_idx_nxt;
  logic [DIST_BITS-1:0]  best_dist_r, best_dist_nxt;
  logic [TOTAL_BITS-1:0] total_r, total_nxt;
  logic [DIST_BITS-1:0]  cmp_a, cmp_b;
  logic                  lt;
  logic                  take;
  logic [TOTAL_BITS:0]   sum;

  // one comparator serves both the selection scan and the relax test
  assign cmp_a = (cmd.op == OP_RELAX) ? edge_w : cand_dist;
  assign cmp_b = (cmd.op == OP_RELAX) ? cand_dist : best_dist_r;
  assign lt    = cmp_a < cmp_b;

  assign take = (cmd.op == OP_SCAN) && !cmd.cand_visited && cmd.cand_reached &&
                (!found_r || lt);
  assign sum  = {1'b0, total_r} + (TOTAL_BITS + 1)'(best_dist_r);

  always_comb begin
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_dist_nxt = best_dist_r;
    total_nxt     = total_r;
    case (cmd.op)
      OP_INIT: begin
        found_nxt = 1'b0;
        total_nxt = '0;
      end
      OP_SCAN_RST: begin
        found_nxt = 1'b0;
      end
      OP_SCAN: begin
        if (take) begin
          found_nxt     = 1'b1;
          best_idx_nxt  = cand_idx;
          best_dist_nxt = cand_dist;
        end
      end
      OP_ACCUM: begin
        total_nxt = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      total_r <= '0;
    end else begin
      found_r <= found_nxt;
      total_r <= total_nxt;
    end
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
  end

  assign stat.found     = found_r;
  assign stat.relax_hit = (cmd.op == OP_RELAX) && !cmd.cand_visited &&
                          (!cmd.cand_reached || lt);
  assign best_idx       = best_idx_r;
  assign best_dist      = best_dist_r;
  assign total          = total_r;

endmodule

// ===== src/prim_spanning_tree_weight.sv =====
// Minimum spanning tree weight engine. Clear and add-edge items give no
// result; edges go into an edge memory in load order. A run item first
// sweeps the vertex memory, one vertex a cycle, for n vertices (n the capped
// vertex count), then does up to n rounds: a selection scan through the
// vertex memory, then an edge pass over all loaded edges that reads and
// relaxes the target vertex of each edge whose source is the chosen vertex.
// The work is serialized through the single compare unit and the one read
// port of each memory. The block takes no item during a run.
// depends on pst_pkg, pst_ram, pst_unit and the assertion macro header
`include "prim_spanning_tree_weight_assert.svh"

module prim_spanning_tree_weight import pst_pkg::*; #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [VTX_BITS-1:0]   in_edge_source,
  input  logic [VTX_BITS-1:0]   in_edge_target,
  input  logic [COST_BITS-1:0]  in_edge_cost,
  input  logic [VTX_BITS-1:0]   in_start_vertex,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TOTAL_BITS-1:0] out_tree_weight,
  output logic                  out_status,
  output logic                  out_edges_dropped,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_BITS-1:0]   cfg_vertex_count
);

  localparam int VDEPTH = (MAX_VERTICES < (1 << VTX_BITS)) ? MAX_VERTICES : (1 << VTX_BITS);
  localparam int VA     = $clog2(VDEPTH);
  localparam int EA     = $clog2(MAX_EDGES);
  localparam int EC     = $clog2(MAX_EDGES + 1);
  localparam int WB     = (WEIGHT_BITS < COST_BITS) ? WEIGHT_BITS : COST_BITS;
  localparam int EW     = 2 * VTX_BITS + WB;
  localparam int VW     = WB + 2;

  localparam logic [CNT_BITS-1:0] VLIMIT  = CNT_BITS'(VDEPTH);
  localparam logic [31:0]         MAXV32  = 32'(MAX_VERTICES);
  localparam logic [EC-1:0]       ECAP    = EC'(MAX_EDGES);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_CLEAR      = 4'd1;
  localparam logic [3:0] S_SCAN       = 4'd2;
  localparam logic [3:0] S_PICK       = 4'd3;
  localparam logic [3:0] S_EDGE_ISSUE = 4'd4;
  localparam logic [3:0] S_EDGE_CHK   = 4'd5;
  localparam logic [3:0] S_VTX        = 4'd6;
  localparam logic [3:0] S_DONE       = 4'd7;

  logic [3:0]            state_r, state_nxt;
  logic [CNT_BITS-1:0]   vcount_r;
  logic [CNT_BITS-1:0]   run_n_r, run_n_nxt;
  logic [VTX_BITS-1:0]   start_r, start_nxt;
  logic [CNT_BITS-1:0]   j_r, j_nxt, j_inc;
  logic [CNT_BITS-1:0]   round_r, round_nxt, round_inc;
  logic                  scan_v_r, scan_v_nxt;
  logic [VA-1:0]         scan_idx_r, scan_idx_nxt;
  logic [EC-1:0]         e_r, e_nxt, e_inc;
  logic [EC-1:0]         edge_cnt_r, edge_cnt_nxt;
  logic                  drop_r, drop_nxt;
  logic [TOTAL_BITS-1:0] res_weight_r, res_weight_nxt;
  logic                  res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [TOTAL_BITS-1:0] out_tree_weight_r;
  logic                  out_status_r;
  logic                  out_drop_r;
  logic                  out_load;
  logic                  in_fire;
  logic [CNT_BITS-1:0]   n_cap;

  logic                  eram_we;
  logic [EA-1:0]         eram_waddr;
  logic [EW-1:0]         eram_wdata;
  logic                  eram_re;
  logic [EA-1:0]         eram_raddr;
  logic [EW-1:0]         eram_rdata;
  logic [VTX_BITS-1:0]   e_from, e_to;
  logic [WB-1:0]         e_w;

  logic                  vram_we;
  logic [VA-1:0]         vram_waddr;
  logic [VW-1:0]         vram_wdata;
  logic                  vram_re;
  logic [VA-1:0]         vram_raddr;
  logic [VW-1:0]         vram_rdata;

  pst_cmd_t              cmd;
  logic [2:0]            op;
  pst_stat_t             stat;
  logic [VA-1:0]         best_idx;
  logic [WB-1:0]         best_dist;
  logic [TOTAL_BITS-1:0] total;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign n_cap = ({{(32 - CNT_BITS){1'b0}}, vcount_r} > MAXV32) ? MAXV32[CNT_BITS-1:0]
                                                               : vcount_r;
  assign j_inc     = j_r + 1'b1;
  assign round_inc = round_r + 1'b1;
  assign e_inc     = e_r + 1'b1;

  assign e_from = eram_rdata[EW-1 -: VTX_BITS];
  assign e_to   = eram_rdata[WB + VTX_BITS - 1 -: VTX_BITS];
  assign e_w    = eram_rdata[WB-1:0];

  assign cmd.op           = op;
  assign cmd.cand_visited = vram_rdata[VW-1];
  assign cmd.cand_reached = vram_rdata[VW-2];

  always_comb begin
    state_nxt      = state_r;
    run_n_nxt      = run_n_r;
    start_nxt      = start_r;
    j_nxt          = j_r;
    round_nxt      = round_r;
    scan_v_nxt     = scan_v_r;
    scan_idx_nxt   = scan_idx_r;
    e_nxt          = e_r;
    edge_cnt_nxt   = edge_cnt_r;
    drop_nxt       = drop_r;
    res_weight_nxt = res_weight_r;
    res_status_nxt = res_status_r;
    out_load       = 1'b0;
    op             = OP_IDLE;
    eram_we        = 1'b0;
    eram_waddr     = edge_cnt_r[EA-1:0];
    eram_wdata     = {in_edge_source, in_edge_target, in_edge_cost[WB-1:0]};
    eram_re        = 1'b0;
    eram_raddr     = e_r[EA-1:0];
    vram_we        = 1'b0;
    vram_waddr     = j_r[VA-1:0];
    vram_wdata     = {1'b0, (j_r == {1'b0, start_r}), {WB{1'b0}}};
    vram_re        = 1'b0;
    vram_raddr     = j_r[VA-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_CLEAR: begin
              edge_cnt_nxt = '0;
              drop_nxt     = 1'b0;
            end
            ACT_ADD: begin
              if (edge_cnt_r < ECAP) begin
                eram_we      = 1'b1;
                edge_cnt_nxt = edge_cnt_r + 1'b1;
              end else begin
                drop_nxt = 1'b1;
              end
            end
            ACT_RUN: begin
              op        = OP_INIT;
              run_n_nxt = n_cap;
              start_nxt = in_start_vertex;
              j_nxt     = '0;
              if (n_cap == '0) begin
                res_weight_nxt = '0;
                res_status_nxt = 1'b0;
                state_nxt      = S_DONE;
              end else if (n_cap > VLIMIT) begin
                // vertices beyond the index range are never reachable
                res_weight_nxt = '0;
                res_status_nxt = 1'b1;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_CLEAR;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CLEAR: begin
        op      = OP_SCAN_RST;
        vram_we = 1'b1;
        j_nxt   = j_inc;
        if (j_inc == run_n_r) begin
          j_nxt      = '0;
          round_nxt  = '0;
          scan_v_nxt = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        op = scan_v_r ? OP_SCAN : OP_IDLE;
        if (j_r < run_n_r) begin
          vram_re      = 1'b1;
          j_nxt        = j_inc;
          scan_v_nxt   = 1'b1;
          scan_idx_nxt = j_r[VA-1:0];
        end else begin
          scan_v_nxt = 1'b0;
          if (!scan_v_r) begin
            state_nxt = S_PICK;
          end
        end
      end
      S_PICK: begin
        if (!stat.found) begin
          res_weight_nxt = '0;
          res_status_nxt = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          op         = OP_ACCUM;
          vram_we    = 1'b1;
          vram_waddr = best_idx;
          vram_wdata = {1'b1, 1'b1, best_dist};
          e_nxt      = '0;
          state_nxt  = S_EDGE_ISSUE;
        end
      end
      S_EDGE_ISSUE: begin
        if (e_r < edge_cnt_r) begin
          eram_re   = 1'b1;
          state_nxt = S_EDGE_CHK;
        end else begin
          round_nxt = round_inc;
          if (round_inc == run_n_r) begin
            res_weight_nxt = total;
            res_status_nxt = 1'b0;
            state_nxt      = S_DONE;
          end else begin
            op        = OP_SCAN_RST;
            j_nxt     = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_EDGE_CHK: begin
        if ((e_from == VTX_BITS'(best_idx)) && ({1'b0, e_to} < run_n_r)) begin
          vram_re    = 1'b1;
          vram_raddr = e_to[VA-1:0];
          state_nxt  = S_VTX;
        end else begin
          e_nxt = e_inc;
          if (e_inc < edge_cnt_r) begin
            eram_re    = 1'b1;
            eram_raddr = e_inc[EA-1:0];
          end else begin
            round_nxt = round_inc;
            if (round_inc == run_n_r) begin
              res_weight_nxt = total;
              res_status_nxt = 1'b0;
              state_nxt      = S_DONE;
            end else begin
              op        = OP_SCAN_RST;
              j_nxt     = '0;
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_VTX: begin
        op = OP_RELAX;
        if (stat.relax_hit) begin
          vram_we    = 1'b1;
          vram_waddr = e_to[VA-1:0];
          vram_wdata = {1'b0, 1'b1, e_w};
        end
        e_nxt     = e_inc;
        state_nxt = S_EDGE_ISSUE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= CNT_BITS'(1);
      scan_v_r    <= 1'b0;
      edge_cnt_r  <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_v_r    <= scan_v_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_vertex_count;
      end
    end
    run_n_r      <= run_n_nxt;
    start_r      <= start_nxt;
    j_r          <= j_nxt;
    round_r      <= round_nxt;
    scan_idx_r   <= scan_idx_nxt;
    e_r          <= e_nxt;
    res_weight_r <= res_weight_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_tree_weight_r <= res_weight_r;
      out_status_r      <= res_status_r;
      out_drop_r        <= drop_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tree_weight   = out_tree_weight_r;
  assign out_status        = out_status_r;
  assign out_edges_dropped = out_drop_r;

  pst_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (eram_we),
    .waddr (eram_waddr),
    .wdata (eram_wdata),
    .re    (eram_re),
    .raddr (eram_raddr),
    .rdata (eram_rdata)
  );

  pst_ram #(
    .WIDTH (VW),
    .DEPTH (VDEPTH)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .re    (vram_re),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  pst_unit #(
    .DIST_BITS (WB),
    .IDX_BITS  (VA)
  ) u_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cand_idx  (scan_idx_r),
    .cand_dist (vram_rdata[WB-1:0]),
    .edge_w    (e_w),
    .stat      (stat),
    .best_idx  (best_idx),
    .best_dist (best_dist),
    .total     (total)
  );

  `PST_ASSERT_IMP(a_vram_no_collide, clk, rst_n, vram_we && vram_re, vram_waddr != vram_raddr)
  `PST_ASSERT_IMP(a_edge_cnt_cap, clk, rst_n, 1'b1, edge_cnt_r <= ECAP)
  `PST_ASSERT_IMP(a_disc_zero, clk, rst_n, out_valid_r && out_status_r, out_tree_weight_r == '0)
  `PST_ASSERT_NXT(a_run_busy, clk, rst_n, in_fire && (in_action == ACT_RUN), !in_ready)

endmodule
